// ===== hdl/pal_pkg.sv =====
// Shared types and constants for the positional array list.
package pal_pkg;

  // Defaults and limits for the list store.
  localparam int unsigned PAL_DEPTH      = 128;
  localparam int unsigned PAL_DATA_WIDTH = 32;
  localparam int unsigned PAL_MAX_DEPTH  = 1024;

  // Width that holds any list index or count up to the largest depth.
  localparam int unsigned POS_W = $clog2(PAL_MAX_DEPTH + 1);

  // Fixed field widths of the item ports.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POSIN_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  // Cells per readout group; the readout is an OR over a group, then over groups.
  localparam int unsigned GRP_SIZE = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== hdl/pal_cell.sv =====
// One storage cell of the list chain: holds a single entry.
module pal_cell import pal_pkg::*; #(
  parameter int unsigned DATA_WIDTH = PAL_DATA_WIDTH,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  at_pos, above_pos;

  assign at_pos    = (MY_IDX == ctrl_i.pos);
  assign above_pos = (MY_IDX > ctrl_i.pos);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (at_pos) begin
          entry_d = value_i;
        end else if (above_pos) begin
          entry_d = prev_i;
        end
      end
      CELL_DELETE: begin
        if (at_pos || above_pos) begin
          entry_d = next_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Offer the entry to the readout OR only at the addressed position.
  assign tap_o   = at_pos ? entry_q : '0;

endmodule

// ===== hdl/positional_array_list_core.sv =====
// Top level of the positional array list: control, cell chain and readout.
//
// Usage
//   Input channel: command_i, position_i, value_i with in_valid_i / in_stall_o.
//   An item is taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: data_out_o, status_o, count_after_o with out_valid_o /
//   out_stall_i; one result item per input item, in order.
//   Commands: insert at a position, append, delete at a position (returns the
//   removed entry) and read. Bad positions and a full list are reported in
//   status_o and leave the list untouched; data_out_o is zero then.
// Sequence
//   An item goes through these steps in order: the edge that takes it, an
//   execute edge where the whole cell chain shifts at once while group ORs
//   capture the addressed entry, and a collect edge that folds the group ORs
//   into the output register. in_stall_o stays high from the edge that takes
//   an item until its result is loaded, so a new item waits for the last one.
// Reset and backpressure
//   Reset empties the list (count zero) and drops any pending result. Entry
//   contents are not cleared. While out_stall_i holds a result, the block
//   still takes one more item and runs it up to the readout, then waits there
//   until the output register is free.
module positional_array_list_core import pal_pkg::*; #(
  parameter int unsigned DEPTH      = PAL_DEPTH,
  parameter int unsigned DATA_WIDTH = PAL_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [POSIN_W-1:0]    position_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] data_out_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [COUNT_W-1:0]    count_after_o
);

  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned NGROUP  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

  // Sequencer states.
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_COLLECT = 2'd2;

  logic [1:0] state_q, state_d;

  // Held item.
  cmd_e                  cmd_q;
  logic [POSIN_W-1:0]    pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;

  logic [DATA_WIDTH-1:0] data_q;
  logic [STATUS_W-1:0]   stat_out_q;
  logic [COUNT_W-1:0]    cnt_out_q;
  logic                  out_valid_q;

  logic [POS_W-1:0] pos_ext, cnt_ext;
  logic             is_full;
  cell_ctrl_t       ctrl;
  logic             out_load;

  assign pos_ext = POS_W'(pos_q);
  assign cnt_ext = POS_W'(count_q);
  assign is_full = (cnt_ext >= DEPTH_P);

  // Decide status, cell action and new count for the held item.
  always_comb begin
    status_d = STAT_OK;
    count_d  = count_q;
    ctrl.op  = CELL_HOLD;
    ctrl.pos = pos_ext;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_d = STAT_RANGE;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_APPEND: begin
        ctrl.pos = cnt_ext;
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = STAT_RANGE;
        end else begin
          ctrl.op = CELL_DELETE;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        if (pos_ext >= cnt_ext) begin
          status_d = STAT_RANGE;
        end
      end
    endcase
    // Cells only move in the execute cycle.
    if (state_q != S_EXEC) begin
      ctrl.op = CELL_HOLD;
    end
  end

  // Cell chain.
  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DATA_WIDTH-1:0] tap_pad [NGROUP*GRP_SIZE];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = val_q;
    end else begin : g_mid
      assign prev_w = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = entry[i];
    end else begin : g_inner
      assign next_w = entry[i+1];
    end
    pal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (val_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry[i]),
      .tap_o   (tap_pad[i])
    );
  end

  for (genvar i = DEPTH; i < NGROUP*GRP_SIZE; i++) begin : g_pad
    assign tap_pad[i] = '0;
  end

  // Readout, first level: OR of each group, captured before the chain moves.
  logic [DATA_WIDTH-1:0] grp_q [NGROUP];

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    logic [DATA_WIDTH-1:0] grp_d;
    always_comb begin
      grp_d = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_d = grp_d | tap_pad[g*GRP_SIZE + k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (state_q == S_EXEC) begin
        grp_q[g] <= grp_d;
      end
    end
  end

  // Readout, second level: OR across groups.
  logic [DATA_WIDTH-1:0] fold;
  always_comb begin
    fold = '0;
    for (int g = 0; g < NGROUP; g++) begin
      fold = fold | grp_q[g];
    end
  end

  assign out_load = (state_q == S_COLLECT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_EXEC;
      S_EXEC:    state_d = S_COLLECT;
      S_COLLECT: if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        count_q <= count_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= cmd_e'(command_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
    end
    if (out_load) begin
      // Drop data unless a successful read or delete produced it.
      data_q     <= (status_q == STAT_OK && (cmd_q == CMD_DELETE || cmd_q == CMD_READ))
                    ? fold : '0;
      stat_out_q <= status_q;
      cnt_out_q  <= COUNT_W'(count_q);
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign data_out_o    = data_q;
  assign status_o      = stat_out_q;
  assign count_after_o = cnt_out_q;

endmodule

// ===== hdl/pal_checker.sv =====
// Port-level assertions for the positional array list, bound to the top level.
module pal_checker import pal_pkg::*; #(
  parameter int unsigned DEPTH      = PAL_DEPTH,
  parameter int unsigned DATA_WIDTH = PAL_DATA_WIDTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] data_out_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic [COUNT_W-1:0]    count_after_o
);

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(status_o) && $stable(count_after_o))
    else $error("stalled result changed");

  // A taken item blocks the next one for the following cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken back to back");

  // A full report only comes with a full list.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> count_after_o == DEPTH_C)
    else $error("full status with list not full");

  // Any error returns zero data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> data_out_o == '0)
    else $error("error result carries data");

endmodule

bind positional_array_list_core pal_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_pal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .data_out_o    (data_out_o),
  .status_o      (status_o),
  .count_after_o (count_after_o)
);

// ===== tb/positional_array_list_core_tb.sv =====
// Self-checking testbench for the positional array list core.
module positional_array_list_core_tb;
  import pal_pkg::*;

  localparam int unsigned LIST_DEPTH  = PAL_DEPTH;
  localparam int unsigned DW          = PAL_DATA_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned BATCHES     = 8;
  localparam int unsigned BATCH_ITEMS = 80;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    cmd_e               cmd;
    logic [POSIN_W-1:0] pos;
    logic [DW-1:0]      value;
  } list_cmd_t;

  typedef struct packed {
    logic [DW-1:0]      data;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i   = '0;
  logic [POSIN_W-1:0]   position_i  = '0;
  logic [DW-1:0]        value_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DW-1:0]        data_out_o;
  logic [STATUS_W-1:0]  status_o;
  logic [COUNT_W-1:0]   count_after_o;

  positional_array_list_core #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (DW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .count_after_o (count_after_o)
  );

  // Commands waiting for the driver, and results the list still owes us.
  list_cmd_t    cmd_pending[$];
  list_result_t expected_results[$];

  // Shadow list: contents and length as the core should hold them.
  logic [DW-1:0] list_mem [LIST_DEPTH];
  int            list_len = 0;

  // Length seen by the generator, which runs ahead of acceptance.
  int gen_count  = 0;
  bit grow_mode  = 1'b1;
  int full_hits  = 0;

  // Idle and stall odds per phase, in percent; set only between phases.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // Long receiver hold-off: the stimulus bumps the request count, the
  // receiver process serves it and counts the cycles down itself.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int err_count = 0;
  int cycle_cnt = 0;
  bit in_took   = 1'b0;

  initial forever #10 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the result it owes.
  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    int           idx;
    r.data   = '0;
    r.status = STAT_OK;
    case (c.cmd)
      CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else if (int'(c.pos) > list_len) begin
          r.status = STAT_RANGE;
        end else begin
          // Shift the tail up one slot, then drop the value into the gap.
          for (idx = list_len; idx > int'(c.pos); idx--) list_mem[idx] = list_mem[idx-1];
          list_mem[c.pos] = c.value;
          list_len++;
        end
      end
      CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          list_mem[list_len] = c.value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (int'(c.pos) >= list_len) begin
          r.status = STAT_RANGE;
        end else begin
          // Return the removed entry and close the gap from above.
          r.data = list_mem[c.pos];
          for (idx = c.pos; idx + 1 < list_len; idx++) list_mem[idx] = list_mem[idx+1];
          list_len--;
        end
      end
      default: begin
        if (int'(c.pos) >= list_len) r.status = STAT_RANGE;
        else r.data = list_mem[c.pos];
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Queue one command and track the length it leaves behind.
  task automatic push_item(cmd_e cmd, int pos, logic [DW-1:0] value);
    list_cmd_t c;
    c.cmd   = cmd;
    c.pos   = pos[POSIN_W-1:0];
    c.value = value;
    cmd_pending.push_back(c);
    case (cmd)
      CMD_INSERT: if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
      CMD_APPEND: if (gen_count < LIST_DEPTH) gen_count++;
      CMD_DELETE: if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DW-1){1'b0}}};
      3:       return {1'b0, {(DW-1){1'b1}}};
      default: return DW'($urandom);
    endcase
  endfunction

  // Random commands that swing the list from empty to full and back.
  task automatic gen_random_items(int n);
    cmd_e cmd;
    int   pos;
    int   r;
    repeat (n) begin
      if (!grow_mode && gen_count == 0) grow_mode = 1'b1;
      r = $urandom_range(99);
      if (grow_mode) begin
        cmd = r < 50 ? CMD_INSERT : r < 85 ? CMD_APPEND : r < 92 ? CMD_DELETE : CMD_READ;
      end else begin
        cmd = r < 8 ? CMD_INSERT : r < 16 ? CMD_APPEND : r < 70 ? CMD_DELETE : CMD_READ;
      end
      // Aim mostly at legal positions; leave some noise over the full field.
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(255);
      end else if (cmd == CMD_INSERT) begin
        pos = $urandom_range(99) < 20 ? gen_count : $urandom_range(gen_count);
      end else begin
        pos = gen_count == 0 ? 0 : $urandom_range(gen_count - 1);
      end
      // Hammer a full list a few times, bad positions included, then drain.
      if (grow_mode && gen_count == LIST_DEPTH) begin
        cmd = $urandom_range(1) ? CMD_INSERT : CMD_APPEND;
        pos = $urandom_range(255);
        full_hits++;
        if (full_hits >= 5) begin
          grow_mode = 1'b0;
          full_hits = 0;
        end
      end
      push_item(cmd, pos, pick_value());
    end
  endtask

  // Hold the sender back until every queued item is through and answered.
  task automatic wait_drained();
    while (cmd_pending.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Driver: present a new item once the last one is taken or none is up.
  always @(negedge clk_i) begin : drive_proc
    list_cmd_t nxt;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (cmd_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = cmd_pending.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= nxt.cmd;
        position_i <= nxt.pos;
        value_i    <= nxt.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: serve a pending hold-off first, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk_i) begin : check_proc
    list_cmd_t    got_cmd;
    list_result_t want;
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      got_cmd.cmd   = cmd_e'(command_i);
      got_cmd.pos   = position_i;
      got_cmd.value = value_i;
      expected_results.push_back(apply_list_cmd(got_cmd));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result with none expected: data %h status %0d count %0d",
                             data_out_o, status_o, count_after_o));
      end else begin
        want = expected_results.pop_front();
        if (data_out_o !== want.data)
          flag_error($sformatf("data_out expected %h got %h", want.data, data_out_o));
        if (status_o !== want.status)
          flag_error($sformatf("status expected %0d got %0d", want.status, status_o));
        if (count_after_o !== want.count)
          flag_error($sformatf("count_after expected %0d got %0d", want.count, count_after_o));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** positional_array_list_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list errors, value extremes, boundary positions.
    push_item(CMD_READ,   0,   '0);
    push_item(CMD_DELETE, 0,   '0);
    push_item(CMD_INSERT, 1,   32'h1234_5678);
    push_item(CMD_INSERT, 0,   32'h7FFF_FFFF);
    push_item(CMD_APPEND, 0,   32'h8000_0000);
    push_item(CMD_INSERT, 2,   32'h0000_0000);
    push_item(CMD_INSERT, 255, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 1,   32'hFFFF_FFFF);
    push_item(CMD_APPEND, 200, 32'h5A5A_A5A5);
    push_item(CMD_INSERT, 4,   32'h0000_0001);
    push_item(CMD_READ,   0,   32'hDEAD_BEEF);
    push_item(CMD_READ,   5,   '0);
    push_item(CMD_READ,   6,   '0);
    push_item(CMD_READ,   128, '0);
    push_item(CMD_READ,   255, '0);
    push_item(CMD_DELETE, 2,   32'hCAFE_F00D);
    push_item(CMD_DELETE, 4,   '0);
    push_item(CMD_DELETE, 4,   '0);
    push_item(CMD_DELETE, 0,   '0);
    push_item(CMD_DELETE, 200, '0);
    push_item(CMD_READ,   2,   '0);
    push_item(CMD_INSERT, 3,   32'hA5A5_5A5A);
    wait_drained();

    // Random phases; drain between them so the sender pauses at each seam.
    for (int b = 0; b < BATCHES; b++) begin
      case (b % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // Back up the output while items keep coming so the input stalls.
      if (b % 4 == 0) hold_requests++;
      gen_random_items(BATCH_ITEMS);
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("** positional_array_list_core: PASSED **");
    end else begin
      $display("** positional_array_list_core: FAILED **");
    end
    $finish;
  end

endmodule
